### hdl/flvdr_pkg.sv
// ----------------------------------------------------------------------------
// flvdr_pkg
// shared types and constants of the flv tag deframer with timestamp rebasing
// ----------------------------------------------------------------------------
package flvdr_pkg;

   // parse phase
   typedef enum logic [1:0] {
      PH_FILE   = 2'd0,
      PH_TAGHDR = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   // region codes on the result side
   localparam logic [1:0] REGION_FILE    = 2'd0;
   localparam logic [1:0] REGION_TAGHDR  = 2'd1;
   localparam logic [1:0] REGION_PAYLOAD = 2'd2;
   localparam logic [1:0] REGION_TRAILER = 2'd3;

   // tag kind codes on the result side
   localparam logic [1:0] KIND_AUDIO  = 2'd0;
   localparam logic [1:0] KIND_VIDEO  = 2'd1;
   localparam logic [1:0] KIND_SCRIPT = 2'd2;

   // tag type bytes in the stream
   localparam logic [7:0] TAG_AUDIO  = 8'd8;
   localparam logic [7:0] TAG_VIDEO  = 8'd9;
   localparam logic [7:0] TAG_SCRIPT = 8'd18;

   // file header
   localparam logic [7:0] SIG_F       = 8'h46;
   localparam logic [7:0] SIG_L       = 8'h4C;
   localparam logic [7:0] SIG_V       = 8'h56;
   localparam logic [7:0] FLV_VERSION = 8'h01;
   localparam logic [7:0] FLAG_RSVD   = 8'hFA;
   localparam logic [3:0] FRAME_KEY   = 4'h1;

   // byte positions inside the file header and tag header
   localparam logic [3:0] FH_SIG0       = 4'd0;
   localparam logic [3:0] FH_SIG1       = 4'd1;
   localparam logic [3:0] FH_SIG2       = 4'd2;
   localparam logic [3:0] FH_VERSION    = 4'd3;
   localparam logic [3:0] FH_FLAGS      = 4'd4;
   localparam logic [3:0] FH_PREV_FIRST = 4'd9;
   localparam logic [3:0] FH_LAST       = 4'd12;

   localparam logic [3:0] TH_TYPE      = 4'd0;
   localparam logic [3:0] TH_SIZE_HI   = 4'd1;
   localparam logic [3:0] TH_SIZE_MID  = 4'd2;
   localparam logic [3:0] TH_SIZE_LO   = 4'd3;
   localparam logic [3:0] TH_TIME_HI   = 4'd4;
   localparam logic [3:0] TH_TIME_MID  = 4'd5;
   localparam logic [3:0] TH_TIME_LO   = 4'd6;
   localparam logic [3:0] TH_STREAM_ID = 4'd8;
   localparam logic [3:0] TH_LAST      = 4'd10;

   localparam logic [24:0] TRAILER_BYTES = 25'd4;

   // one result
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  region;
      logic [1:0]  tag_kind;
      logic        key_frame;
      logic [23:0] anchor_time;
      logic        tag_end;
      logic        format_error;
   } rsp_type;

endpackage

### hdl/flv_tag_deframer_rebase_core.sv
// ----------------------------------------------------------------------------
// flv_tag_deframer_rebase_core
// flv byte stream parser with tag timestamp rebasing
// ----------------------------------------------------------------------------
// Takes one flv stream byte per request and checks the 13-byte file header
// and every tag header; each byte is passed on tagged with its region, tag
// kind, keyframe flag, anchor timestamp and end-of-tag mark, and the tag
// timestamp is rewritten as timestamp minus csr_wdata's offset, modulo 2^24.
// The first two timestamp bytes give no result and the third gives three,
// so over a whole tag the block accepts and delivers one byte per clock while the result side does not stall.
// Parsing is done in one pass at the accept edge; results go to an 8-entry
// output queue, and req_stall is high while fewer than three entries are
// free. With the result side never stalled the queue holds at most three
// entries, so a request is taken every clock and req_stall only rises
// when the result side holds off. A format violation is delivered once
// with format_error set, then all further requests are accepted and
// dropped until reset. Write the offset only while the block is idle.
module flv_tag_deframer_rebase_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_region,
   output logic [1:0]  rsp_tag_kind,
   output logic        rsp_key_frame,
   output logic [23:0] rsp_anchor_time,
   output logic        rsp_tag_end,
   output logic        rsp_format_error,
   // offset register
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   import flvdr_pkg::*;

   localparam int QDEPTH = 8;
   localparam int QAW    = $clog2(QDEPTH);

   function automatic rsp_type mk_rsp(input logic [7:0] b, input logic [1:0] region,
                                      input logic [1:0] kind, input logic key,
                                      input logic [23:0] anchor, input logic tend,
                                      input logic err);
      rsp_type r;
      r.out_byte     = b;
      r.region       = region;
      r.tag_kind     = kind;
      r.key_frame    = key;
      r.anchor_time  = anchor;
      r.tag_end      = tend;
      r.format_error = err;
      return r;
   endfunction

   // parser state
   phase_type   phase_ff, phase_in;
   logic [3:0]  byte_index_ff, byte_index_in;
   logic [24:0] bytes_left_ff, bytes_left_in;
   logic [23:0] tag_time_ff, tag_time_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  kind_ff, kind_in;
   logic        key_ff, key_in;
   logic        key_seen_ff, key_seen_in;
   logic [23:0] anchor_ff, anchor_in;
   logic        error_stuck_ff, error_stuck_in;
   logic [23:0] offset_ff;

   // output queue
   rsp_type          queue_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]     count_ff, count_in;

   rsp_type     res [3];
   logic [1:0]  n_push;
   logic        accept, pop, bad, emit_one;
   logic [7:0]  b;
   logic [23:0] ts;
   logic [1:0]  body_region;
   logic        body_end;

   assign b         = req_in_byte;
   // room for a full timestamp burst is required before taking a request
   assign req_stall = (count_ff > (QAW+1)'(QDEPTH - 3));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_out_byte     = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_region       = queue_ff[rd_ptr_ff].region;
   assign rsp_tag_kind     = queue_ff[rd_ptr_ff].tag_kind;
   assign rsp_key_frame    = queue_ff[rd_ptr_ff].key_frame;
   assign rsp_anchor_time  = queue_ff[rd_ptr_ff].anchor_time;
   assign rsp_tag_end      = queue_ff[rd_ptr_ff].tag_end;
   assign rsp_format_error = queue_ff[rd_ptr_ff].format_error;

   // next state and results of the accepted byte
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      bytes_left_in  = bytes_left_ff;
      tag_time_in    = tag_time_ff;
      held_in        = held_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      key_seen_in    = key_seen_ff;
      anchor_in      = anchor_ff;
      error_stuck_in = error_stuck_ff;
      n_push         = 2'd0;
      bad            = 1'b0;
      emit_one       = 1'b1;
      ts             = (tag_time_in - offset_ff);
      body_region    = REGION_PAYLOAD;
      body_end       = 1'b0;
      res[0]         = '0;
      res[1]         = '0;
      res[2]         = '0;

      if (accept && !error_stuck_ff) begin
         unique case (phase_ff)
            PH_FILE: begin
               case (byte_index_ff)
                  FH_SIG0:    bad = (b != SIG_F);
                  FH_SIG1:    bad = (b != SIG_L);
                  FH_SIG2:    bad = (b != SIG_V);
                  FH_VERSION: bad = (b != FLV_VERSION);
                  FH_FLAGS:   bad = ((b & FLAG_RSVD) != 8'd0);
                  default:    bad = (byte_index_ff >= FH_PREV_FIRST) && (b != 8'd0);
               endcase
               res[0] = mk_rsp(b, REGION_FILE, kind_ff, key_ff, anchor_ff, 1'b0, bad);
               n_push = 2'd1;
               if (bad) begin
                  error_stuck_in = 1'b1;
               end else if (byte_index_ff >= FH_LAST) begin
                  phase_in      = PH_TAGHDR;
                  byte_index_in = '0;
               end else begin
                  byte_index_in = byte_index_ff + 4'd1;
               end
            end
            PH_TAGHDR: begin
               case (byte_index_ff)
                  TH_TYPE: begin
                     if (b == TAG_AUDIO) begin
                        kind_in = KIND_AUDIO;
                     end else if (b == TAG_VIDEO) begin
                        kind_in = KIND_VIDEO;
                     end else if (b == TAG_SCRIPT) begin
                        kind_in = KIND_SCRIPT;
                     end else begin
                        bad = 1'b1;
                     end
                     if (!bad) begin
                        key_in = 1'b0;
                     end
                  end
                  TH_SIZE_HI:  bytes_left_in = {17'd0, b};
                  TH_SIZE_MID: bytes_left_in = {9'd0, bytes_left_ff[7:0], b};
                  TH_SIZE_LO:  bytes_left_in = {1'b0, bytes_left_ff[15:0], b} + TRAILER_BYTES;
                  TH_TIME_HI: begin
                     held_in  = {8'd0, b};
                     emit_one = 1'b0;
                  end
                  TH_TIME_MID: begin
                     held_in  = {held_ff[7:0], b};
                     emit_one = 1'b0;
                  end
                  TH_TIME_LO: begin
                     // rewritten timestamp goes out as three results at once
                     tag_time_in = {held_ff, b};
                     ts          = tag_time_in - offset_ff;
                     emit_one    = 1'b0;
                     res[0] = mk_rsp(ts[23:16], REGION_TAGHDR, kind_ff, key_ff, anchor_ff,
                                     1'b0, 1'b0);
                     res[1] = mk_rsp(ts[15:8], REGION_TAGHDR, kind_ff, key_ff, anchor_ff,
                                     1'b0, 1'b0);
                     res[2] = mk_rsp(ts[7:0], REGION_TAGHDR, kind_ff, key_ff, anchor_ff,
                                     1'b0, 1'b0);
                     n_push = 2'd3;
                  end
                  default: bad = (byte_index_ff >= TH_STREAM_ID) && (b != 8'd0);
               endcase
               if (bad) begin
                  error_stuck_in = 1'b1;
                  res[0] = mk_rsp(b, REGION_TAGHDR, kind_ff, key_ff, anchor_ff, 1'b0, 1'b1);
                  n_push = 2'd1;
               end else begin
                  if (emit_one) begin
                     res[0] = mk_rsp(b, REGION_TAGHDR, kind_in, key_in, anchor_ff,
                                     1'b0, 1'b0);
                     n_push = 2'd1;
                  end
                  if (byte_index_ff >= TH_LAST) begin
                     phase_in      = PH_BODY;
                     byte_index_in = '0;
                  end else begin
                     byte_index_in = byte_index_ff + 4'd1;
                  end
               end
            end
            PH_BODY: begin
               body_region = (bytes_left_ff > TRAILER_BYTES) ? REGION_PAYLOAD : REGION_TRAILER;
               if (byte_index_ff == '0) begin
                  // keyframe test on the first body byte
                  if ((kind_ff == KIND_VIDEO) && (b[7:4] == FRAME_KEY)) begin
                     key_in      = 1'b1;
                     key_seen_in = 1'b1;
                     anchor_in   = tag_time_ff;
                  end else if (!key_seen_ff) begin
                     anchor_in = tag_time_ff;
                  end
                  byte_index_in = 4'd1;
               end
               if (bytes_left_ff != '0) begin
                  bytes_left_in = bytes_left_ff - 25'd1;
               end
               body_end = (bytes_left_in == '0);
               res[0]   = mk_rsp(b, body_region, kind_ff, key_in, anchor_in, body_end, 1'b0);
               n_push   = 2'd1;
               if (body_end) begin
                  phase_in      = PH_TAGHDR;
                  byte_index_in = '0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign count_in = count_ff + (QAW+1)'(n_push) - (QAW+1)'(pop);

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FILE;
         byte_index_ff  <= '0;
         bytes_left_ff  <= '0;
         tag_time_ff    <= '0;
         held_ff        <= '0;
         kind_ff        <= KIND_AUDIO;
         key_ff         <= 1'b0;
         key_seen_ff    <= 1'b0;
         anchor_ff      <= '0;
         error_stuck_ff <= 1'b0;
         offset_ff      <= '0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         bytes_left_ff  <= bytes_left_in;
         tag_time_ff    <= tag_time_in;
         held_ff        <= held_in;
         kind_ff        <= kind_in;
         key_ff         <= key_in;
         key_seen_ff    <= key_seen_in;
         anchor_ff      <= anchor_in;
         error_stuck_ff <= error_stuck_in;
         if (csr_we) begin
            offset_ff <= csr_wdata;
         end
      end
   end

   // output queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QAW'(n_push);
         rd_ptr_ff <= rd_ptr_ff + QAW'(pop);
         count_ff  <= count_in;
      end
   end

   // output queue storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (k < int'(n_push)) begin
            queue_ff[wr_ptr_ff + QAW'(k)] <= res[k];
         end
      end
   end

endmodule
